### hw/rtl/tdpt_pkg.sv
// ============================================================================
// tdpt_pkg
// Shared types, codes and sizes of the pushdown tokenizer.
// ============================================================================
package tdpt_pkg;

    // Input operations
    localparam logic [1:0] OP_PARSE = 2'd0;
    localparam logic [1:0] OP_TABLE = 2'd1;
    localparam logic [1:0] OP_EOF   = 2'd2;

    // Actions, in table encoding
    localparam logic [4:0] ACT_SKIP   = 5'd0;
    localparam logic [4:0] ACT_TRAIL  = 5'd1;
    localparam logic [4:0] ACT_APPEND = 5'd2;
    localparam logic [4:0] ACT_APPEND_END = 5'd3;
    localparam logic [4:0] ACT_QAPP   = 5'd4;
    localparam logic [4:0] ACT_LQAPP  = 5'd5;
    localparam logic [4:0] ACT_ESCAPP = 5'd6;
    localparam logic [4:0] ACT_SQUOTE = 5'd7;
    localparam logic [4:0] ACT_DQUOTE = 5'd8;
    localparam logic [4:0] ACT_UNQUOTE = 5'd9;
    localparam logic [4:0] ACT_CONT   = 5'd10;
    localparam logic [4:0] ACT_RESTORE = 5'd11;
    localparam logic [4:0] ACT_ESCAPE = 5'd12;
    localparam logic [4:0] ACT_COMMENT = 5'd13;
    localparam logic [4:0] ACT_IGNORE = 5'd14;
    localparam logic [4:0] ACT_BACKOFF = 5'd15;
    localparam logic [4:0] ACT_DONE   = 5'd16;
    localparam logic [4:0] ACT_FINI   = 5'd17;

    // Parse states
    localparam logic [2:0] ST_NON = 3'd0;
    localparam logic [2:0] ST_SOM = 3'd1;
    localparam logic [2:0] ST_AFT = 3'd2;
    localparam logic [2:0] ST_SIN = 3'd3;
    localparam logic [2:0] ST_DBL = 3'd4;
    localparam logic [2:0] ST_ESC = 3'd5;
    localparam logic [2:0] ST_COM = 3'd6;
    localparam logic [2:0] ST_IGN = 3'd7;

    // Word-end status
    localparam logic [1:0] STAT_MORE = 2'd0;
    localparam logic [1:0] STAT_EOL  = 2'd1;
    localparam logic [1:0] STAT_EOF  = 2'd2;
    localparam logic [1:0] STAT_ERR  = 2'd3;

    localparam logic [7:0] CHAR_BSLASH = 8'h5C;
    localparam logic [7:0] CHAR_NUL    = 8'h00;

    localparam int STACK_DEPTH = 64;
    localparam int SP_W        = $clog2(STACK_DEPTH);
    localparam int TABLE_DEPTH = 2048;
    localparam int TADDR_W     = $clog2(TABLE_DEPTH);
    localparam int LIMIT_W     = 13;
    localparam logic [LIMIT_W-1:0] MAX_WORD = 13'd4096;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd256;

    // Stack commands
    localparam logic [2:0] SCMD_NOP      = 3'd0;
    localparam logic [2:0] SCMD_PUSH     = 3'd1;
    localparam logic [2:0] SCMD_POP      = 3'd2;
    localparam logic [2:0] SCMD_POKE_POP = 3'd3;
    localparam logic [2:0] SCMD_POKE     = 3'd4;
    localparam logic [2:0] SCMD_CLEAR    = 3'd5;

    typedef struct packed {
        logic [2:0] cmd;
        logic [2:0] push_val;
    } stack_ctl_t;

    typedef struct packed {
        logic       at_bottom;
        logic       full;
        logic [2:0] top;
        logic [2:0] pop_val;
    } stack_stat_t;

    typedef struct packed {
        logic       char_valid;
        logic [7:0] out_char;
        logic       word_end;
        logic [1:0] status;
        logic       last;
    } result_t;

endpackage

### hw/rtl/tdpt_ifs.sv
// ============================================================================
// tdpt_ifs
// Valid/ready channels for tokenizer input items and result items.
// ============================================================================
interface tdpt_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic [7:0] character;
    logic [2:0] table_row;
    logic [4:0] action_code;

    modport source (output valid, op, character, table_row, action_code, input ready);
    modport sink   (input valid, op, character, table_row, action_code, output ready);
endinterface

interface tdpt_out_if;
    logic       valid;
    logic       ready;
    logic       char_valid;
    logic [7:0] out_char;
    logic       word_end;
    logic [1:0] status;
    logic       last;

    modport source (output valid, char_valid, out_char, word_end, status, last, input ready);
    modport sink   (input valid, char_valid, out_char, word_end, status, last, output ready);
endinterface

### hw/rtl/table_driven_pushdown_tokenizer.sv
// ============================================================================
// table_driven_pushdown_tokenizer
// Splits a character stream into words under control of a loaded action
// table and a context stack.
// ============================================================================
// A parse item whose action finishes at once first reads the action table
// memory, then applies the action and updates the context stack. Both
// append-and-end and escaped append pass an extra state, S_END or S_ESC2.
// Continue and back off issue the table read for the same character in the
// cycle that applies the action. Table writes and end of input finish in the
// idle state. Results pass a one-entry hold stage and an output register, so
// results of one item drain while the next item is taken in; the block only
// stalls when both are full. The action table (2048 entries) holds garbage
// until loaded and is never cleared; the context stack needs no clearing pass
// since only its pointer, pending flag and cached top entry have reset values.
// word_limit must only be written while the block is idle.
// ============================================================================
module table_driven_pushdown_tokenizer (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        word_limit_we,
    input  logic [tdpt_pkg::LIMIT_W-1:0] word_limit_wdata,
    tdpt_in_if.sink                     chars,
    tdpt_out_if.source                  words
);

    // Sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOOK = 2'd1;
    localparam logic [1:0] S_ESC2 = 2'd2;
    localparam logic [1:0] S_END  = 2'd3;

    logic [1:0]                   fsm_reg, fsm_next;
    logic [2:0]                   pstate_reg, pstate_next;
    logic [tdpt_pkg::LIMIT_W-1:0] room_reg, room_next;
    logic                         err_reg, err_next;
    logic [7:0]                   char_reg, char_next;
    logic [tdpt_pkg::LIMIT_W-1:0] limit_reg;
    logic [tdpt_pkg::LIMIT_W-1:0] eff_limit;

    logic                         t_we, t_re;
    logic [tdpt_pkg::TADDR_W-1:0] t_raddr;
    logic [4:0]                   act;

    tdpt_pkg::stack_ctl_t         stk_ctl;
    tdpt_pkg::stack_stat_t        stk;

    logic                         emit, done, can_emit;
    tdpt_pkg::result_t            res;
    logic                         accept;

    logic                         do_app;
    logic [7:0]                   app_ch;
    logic                         do_end;
    logic [1:0]                   end_stat;
    logic                         new_word;
    logic                         fresh;

    assign eff_limit   = (limit_reg > tdpt_pkg::MAX_WORD) ? tdpt_pkg::MAX_WORD : limit_reg;
    assign chars.ready = (fsm_reg == S_IDLE) && can_emit;
    assign accept      = chars.valid && chars.ready;

    // A back off in an untouched word would spin forever
    assign fresh = (pstate_reg == tdpt_pkg::ST_NON) && stk.at_bottom
                   && (stk.top == tdpt_pkg::ST_NON) && (room_reg == eff_limit) && !err_reg;

    assign t_we = accept && (chars.op == tdpt_pkg::OP_TABLE);

    always_comb
    begin
        fsm_next        = fsm_reg;
        pstate_next     = pstate_reg;
        room_next       = room_reg;
        err_next        = err_reg;
        char_next       = char_reg;
        t_re            = 1'b0;
        t_raddr         = {pstate_reg, chars.character};
        stk_ctl.cmd     = tdpt_pkg::SCMD_NOP;
        stk_ctl.push_val = pstate_reg;
        do_app          = 1'b0;
        app_ch          = char_reg;
        do_end          = 1'b0;
        end_stat        = tdpt_pkg::STAT_MORE;
        new_word        = 1'b0;
        done            = 1'b0;
        emit            = 1'b0;
        res             = '0;

        unique case (fsm_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (chars.op)
                        tdpt_pkg::OP_PARSE:
                        begin
                            // Issue the table read for this character
                            char_next = chars.character;
                            t_re      = 1'b1;
                            fsm_next  = S_LOOK;
                        end
                        tdpt_pkg::OP_EOF:
                        begin
                            // Drop the partial word and report end of file
                            do_end   = 1'b1;
                            end_stat = tdpt_pkg::STAT_EOF;
                            new_word = 1'b1;
                            done     = 1'b1;
                        end
                        default:
                        begin
                            done = 1'b1;
                        end
                    endcase
                end
            end
            S_LOOK:
            begin
                if (can_emit)
                begin
                    case (act)
                        tdpt_pkg::ACT_TRAIL:
                        begin
                            pstate_next = tdpt_pkg::ST_AFT;
                            done        = 1'b1;
                        end
                        tdpt_pkg::ACT_APPEND:
                        begin
                            do_app      = 1'b1;
                            pstate_next = tdpt_pkg::ST_SOM;
                            done        = 1'b1;
                        end
                        tdpt_pkg::ACT_APPEND_END:
                        begin
                            do_app   = 1'b1;
                            fsm_next = S_END;
                        end
                        tdpt_pkg::ACT_QAPP:
                        begin
                            do_app      = 1'b1;
                            stk_ctl.cmd = tdpt_pkg::SCMD_POKE;
                            done        = 1'b1;
                        end
                        tdpt_pkg::ACT_LQAPP:
                        begin
                            do_app      = 1'b1;
                            stk_ctl.cmd = tdpt_pkg::SCMD_POKE_POP;
                            pstate_next = stk.pop_val;
                            done        = 1'b1;
                        end
                        tdpt_pkg::ACT_ESCAPP:
                        begin
                            // Backslash now, the character itself in S_ESC2
                            do_app   = 1'b1;
                            app_ch   = tdpt_pkg::CHAR_BSLASH;
                            fsm_next = S_ESC2;
                        end
                        tdpt_pkg::ACT_SQUOTE, tdpt_pkg::ACT_DQUOTE, tdpt_pkg::ACT_ESCAPE,
                        tdpt_pkg::ACT_COMMENT, tdpt_pkg::ACT_IGNORE:
                        begin
                            // Push the current state; a full stack flags an error
                            stk_ctl.cmd = tdpt_pkg::SCMD_PUSH;
                            err_next    = err_reg | stk.full;
                            done        = 1'b1;
                            case (act)
                                tdpt_pkg::ACT_SQUOTE:  pstate_next = tdpt_pkg::ST_SIN;
                                tdpt_pkg::ACT_DQUOTE:  pstate_next = tdpt_pkg::ST_DBL;
                                tdpt_pkg::ACT_ESCAPE:  pstate_next = tdpt_pkg::ST_ESC;
                                tdpt_pkg::ACT_COMMENT: pstate_next = tdpt_pkg::ST_COM;
                                default:               pstate_next = tdpt_pkg::ST_IGN;
                            endcase
                        end
                        tdpt_pkg::ACT_UNQUOTE:
                        begin
                            stk_ctl.cmd = tdpt_pkg::SCMD_POKE_POP;
                            pstate_next = stk.pop_val;
                            done        = 1'b1;
                        end
                        tdpt_pkg::ACT_CONT:
                        begin
                            if (stk.at_bottom && (pstate_reg == stk.top))
                            begin
                                // Would loop forever: drop the character
                                err_next = 1'b1;
                                done     = 1'b1;
                            end
                            else
                            begin
                                // Pop and parse the character again
                                stk_ctl.cmd = tdpt_pkg::SCMD_POP;
                                pstate_next = stk.top;
                                t_re        = 1'b1;
                                t_raddr     = {stk.top, char_reg};
                            end
                        end
                        tdpt_pkg::ACT_RESTORE:
                        begin
                            stk_ctl.cmd = tdpt_pkg::SCMD_POP;
                            pstate_next = stk.top;
                            done        = 1'b1;
                        end
                        tdpt_pkg::ACT_BACKOFF:
                        begin
                            if (fresh)
                            begin
                                err_next = 1'b1;
                                done     = 1'b1;
                            end
                            else
                            begin
                                // End this word, restart on the same character
                                do_end   = 1'b1;
                                end_stat = (err_reg || (room_reg == '0)) ?
                                           tdpt_pkg::STAT_ERR : tdpt_pkg::STAT_MORE;
                                new_word = 1'b1;
                                t_re     = 1'b1;
                                t_raddr  = {tdpt_pkg::ST_NON, char_reg};
                            end
                        end
                        tdpt_pkg::ACT_DONE, tdpt_pkg::ACT_FINI:
                        begin
                            do_end   = 1'b1;
                            end_stat = tdpt_pkg::STAT_EOL;
                            new_word = 1'b1;
                            done     = 1'b1;
                        end
                        default:
                        begin
                            done = 1'b1;
                        end
                    endcase
                end
            end
            S_ESC2:
            begin
                if (can_emit)
                begin
                    do_app      = 1'b1;
                    stk_ctl.cmd = tdpt_pkg::SCMD_POKE_POP;
                    pstate_next = stk.pop_val;
                    done        = 1'b1;
                end
            end
            S_END:
            begin
                if (can_emit)
                begin
                    do_end   = 1'b1;
                    end_stat = (err_reg || (room_reg == '0)) ?
                               tdpt_pkg::STAT_ERR : tdpt_pkg::STAT_MORE;
                    new_word = 1'b1;
                    done     = 1'b1;
                end
            end
            default:
            begin
                fsm_next = S_IDLE;
            end
        endcase

        // Append one character if the word buffer has room
        if (do_app)
        begin
            if (room_reg != '0)
            begin
                emit           = 1'b1;
                res.char_valid = 1'b1;
                res.out_char   = app_ch;
                room_next      = room_reg - 1'b1;
            end
            else
            begin
                err_next = 1'b1;
            end
        end

        if (do_end)
        begin
            emit         = 1'b1;
            res.word_end = 1'b1;
            res.status   = end_stat;
            res.out_char = tdpt_pkg::CHAR_NUL;
        end

        // Start a fresh word
        if (new_word)
        begin
            pstate_next = tdpt_pkg::ST_NON;
            stk_ctl.cmd = tdpt_pkg::SCMD_CLEAR;
            room_next   = eff_limit;
            err_next    = 1'b0;
        end

        if (done)
        begin
            fsm_next = S_IDLE;
        end
        res.last = done;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_reg    <= S_IDLE;
            pstate_reg <= tdpt_pkg::ST_NON;
            room_reg   <= tdpt_pkg::LIMIT_RESET;
            err_reg    <= 1'b0;
            limit_reg  <= tdpt_pkg::LIMIT_RESET;
        end
        else
        begin
            fsm_reg    <= fsm_next;
            pstate_reg <= pstate_next;
            room_reg   <= room_next;
            err_reg    <= err_next;
            if (word_limit_we)
            begin
                limit_reg <= word_limit_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
    end

    tdpt_table_ram u_table (
        .clk   (clk),
        .we    (t_we),
        .waddr ({chars.table_row, chars.character}),
        .wdata (chars.action_code),
        .re    (t_re),
        .raddr (t_raddr),
        .rdata (act)
    );

    tdpt_stack u_stack (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (stk_ctl),
        .stat  (stk)
    );

    tdpt_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .emit     (emit),
        .res      (res),
        .done     (done),
        .can_emit (can_emit),
        .words    (words)
    );

endmodule

### hw/rtl/tdpt_table_ram.sv
// ============================================================================
// tdpt_table_ram
// Action table: one write port, one registered read port.
// ============================================================================
module tdpt_table_ram (
    input  logic                         clk,
    input  logic                         we,
    input  logic [tdpt_pkg::TADDR_W-1:0] waddr,
    input  logic [4:0]                   wdata,
    input  logic                         re,
    input  logic [tdpt_pkg::TADDR_W-1:0] raddr,
    output logic [4:0]                   rdata
);

    logic [4:0] mem [tdpt_pkg::TABLE_DEPTH];
    logic [4:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/tdpt_stack.sv
// ============================================================================
// tdpt_stack
// Context stack: top entry cached in a register, lower entries in memory.
// ============================================================================
module tdpt_stack (
    input  logic                    clk,
    input  logic                    rst_n,
    input  tdpt_pkg::stack_ctl_t    ctl,
    output tdpt_pkg::stack_stat_t   stat
);

    logic [2:0]                  mem [tdpt_pkg::STACK_DEPTH];
    logic [2:0]                  rd_data_reg;
    logic [tdpt_pkg::SP_W-1:0]   sp_reg;
    logic [2:0]                  top_reg;
    logic                        pend_reg;
    logic [2:0]                  top_cur;
    logic [2:0]                  poked;
    logic                        full;
    logic                        is_pop;

    // After a pop the new top arrives from memory in the following cycle
    assign top_cur = pend_reg ? rd_data_reg : top_reg;
    assign poked   = (top_cur == tdpt_pkg::ST_NON) ? tdpt_pkg::ST_SOM : top_cur;
    assign full    = (sp_reg == tdpt_pkg::SP_W'(tdpt_pkg::STACK_DEPTH - 1));
    assign is_pop  = (ctl.cmd == tdpt_pkg::SCMD_POP) || (ctl.cmd == tdpt_pkg::SCMD_POKE_POP);

    always_comb
    begin
        stat.at_bottom = (sp_reg == '0);
        stat.full      = full;
        stat.top       = top_cur;
        stat.pop_val   = (ctl.cmd == tdpt_pkg::SCMD_POKE_POP) ? poked : top_cur;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg   <= '0;
            top_reg  <= tdpt_pkg::ST_NON;
            pend_reg <= 1'b0;
        end
        else
        begin
            unique case (ctl.cmd)
                tdpt_pkg::SCMD_PUSH:
                begin
                    if (!full)
                    begin
                        sp_reg  <= sp_reg + 1'b1;
                        top_reg <= ctl.push_val;
                    end
                    else
                    begin
                        top_reg <= top_cur;
                    end
                    pend_reg <= 1'b0;
                end
                tdpt_pkg::SCMD_POP, tdpt_pkg::SCMD_POKE_POP:
                begin
                    if (sp_reg != '0)
                    begin
                        sp_reg   <= sp_reg - 1'b1;
                        pend_reg <= 1'b1;
                    end
                    else
                    begin
                        top_reg  <= stat.pop_val;
                        pend_reg <= 1'b0;
                    end
                end
                tdpt_pkg::SCMD_POKE:
                begin
                    top_reg  <= poked;
                    pend_reg <= 1'b0;
                end
                tdpt_pkg::SCMD_CLEAR:
                begin
                    sp_reg   <= '0;
                    top_reg  <= tdpt_pkg::ST_NON;
                    pend_reg <= 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Spill the old top on push, fetch the next one down on pop
    always_ff @(posedge clk)
    begin
        if ((ctl.cmd == tdpt_pkg::SCMD_PUSH) && !full)
        begin
            mem[sp_reg] <= top_cur;
        end
        if (is_pop && (sp_reg != '0))
        begin
            rd_data_reg <= mem[sp_reg - 1'b1];
        end
    end

endmodule

### hw/rtl/tdpt_out_stage.sv
// ============================================================================
// tdpt_out_stage
// Hold stage plus output register; the hold stage waits until the last
// flag of its item is known.
// ============================================================================
module tdpt_out_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               emit,
    input  tdpt_pkg::result_t  res,
    input  logic               done,
    output logic               can_emit,
    tdpt_out_if.source         words
);

    tdpt_pkg::result_t hold_reg;
    logic              hold_valid_reg;
    tdpt_pkg::result_t out_reg;
    logic              out_valid_reg;
    logic              out_free;
    logic              drain;

    assign out_free = !out_valid_reg || words.ready;
    assign can_emit = !hold_valid_reg || out_free;
    assign drain    = hold_valid_reg && out_free && (hold_reg.last || emit);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (drain)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (words.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (emit)
            begin
                hold_valid_reg <= 1'b1;
            end
            else if (drain)
            begin
                hold_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (drain)
        begin
            out_reg <= hold_reg;
        end
        if (emit)
        begin
            hold_reg <= res;
        end
        else if (done && hold_valid_reg)
        begin
            hold_reg.last <= 1'b1;
        end
    end

    assign words.valid      = out_valid_reg;
    assign words.char_valid = out_reg.char_valid;
    assign words.out_char   = out_reg.out_char;
    assign words.word_end   = out_reg.word_end;
    assign words.status     = out_reg.status;
    assign words.last       = out_reg.last;

endmodule

### tb/tdpt_checker.sv
// ============================================================================
// tdpt_checker
// Watches the character and result channels of the pushdown tokenizer. It
// keeps its own copy of the action table, the context stack and the word
// limit, works out the results of every accepted item, and compares them
// field by field with what the block sends.
// ============================================================================
module tdpt_checker
    import tdpt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               word_limit_we,
    input  logic [LIMIT_W-1:0] word_limit_wdata,
    tdpt_in_if                 chars,
    tdpt_out_if                words,
    output int                 errors,
    output int                 pending
);

    logic [4:0]         act_mem [TABLE_DEPTH];
    logic [2:0]         pstate;
    logic [2:0]         ctx [STACK_DEPTH];
    int                 sp;
    int                 room;
    bit                 err_seen;
    logic [LIMIT_W-1:0] limit;
    result_t            word_q [$];

    function automatic int cap_limit();
        return (limit < MAX_WORD) ? int'(limit) : int'(MAX_WORD);
    endfunction

    task automatic start_word();
        pstate   = ST_NON;
        sp       = 0;
        ctx[0]   = ST_NON;
        room     = cap_limit();
        err_seen = 1'b0;
    endtask

    task automatic put(input logic v, input logic [7:0] c, input logic e,
                       input logic [1:0] st);
        result_t r;
        r.char_valid = v;
        r.out_char   = c;
        r.word_end   = e;
        r.status     = st;
        r.last       = 1'b0;
        word_q.push_back(r);
    endtask

    task automatic add_char(input logic [7:0] c);
        if (room > 0)
        begin
            put(1'b1, c, 1'b0, STAT_MORE);
            room--;
        end
        else
            err_seen = 1'b1;
    endtask

    task automatic push_ctx(input logic [2:0] s);
        if (sp + 1 < STACK_DEPTH)
        begin
            sp++;
            ctx[sp] = s;
        end
        else
            err_seen = 1'b1;
    endtask

    function automatic logic [2:0] pop_ctx();
        logic [2:0] v;
        v = ctx[sp];
        if (sp > 0)
            sp--;
        return v;
    endfunction

    task automatic mark_som();
        if (ctx[sp] == ST_NON)
            ctx[sp] = ST_SOM;
    endtask

    task automatic close_more();
        if (room == 0)
            err_seen = 1'b1;
        put(1'b0, CHAR_NUL, 1'b1, err_seen ? STAT_ERR : STAT_MORE);
    endtask

    // Run one character through the table; continue and back off repeat it.
    task automatic parse_char(input logic [7:0] c);
        logic [4:0] a;
        bit         again;
        again = 1'b1;
        while (again)
        begin
            a     = act_mem[{pstate, c}];
            again = 1'b0;
            case (a)
                ACT_TRAIL:      pstate = ST_AFT;
                ACT_APPEND:
                begin
                    add_char(c);
                    pstate = ST_SOM;
                end
                ACT_APPEND_END:
                begin
                    add_char(c);
                    close_more();
                    start_word();
                end
                ACT_QAPP:
                begin
                    add_char(c);
                    mark_som();
                end
                ACT_LQAPP:
                begin
                    add_char(c);
                    mark_som();
                    pstate = pop_ctx();
                end
                ACT_ESCAPP:
                begin
                    add_char(CHAR_BSLASH);
                    add_char(c);
                    mark_som();
                    pstate = pop_ctx();
                end
                ACT_SQUOTE:
                begin
                    push_ctx(pstate);
                    pstate = ST_SIN;
                end
                ACT_DQUOTE:
                begin
                    push_ctx(pstate);
                    pstate = ST_DBL;
                end
                ACT_UNQUOTE:
                begin
                    mark_som();
                    pstate = pop_ctx();
                end
                ACT_CONT:
                    if (sp == 0 && pstate == ctx[0])
                        err_seen = 1'b1;
                    else
                    begin
                        pstate = pop_ctx();
                        again  = 1'b1;
                    end
                ACT_RESTORE:    pstate = pop_ctx();
                ACT_ESCAPE:
                begin
                    push_ctx(pstate);
                    pstate = ST_ESC;
                end
                ACT_COMMENT:
                begin
                    push_ctx(pstate);
                    pstate = ST_COM;
                end
                ACT_IGNORE:
                begin
                    push_ctx(pstate);
                    pstate = ST_IGN;
                end
                ACT_BACKOFF:
                    if (pstate == ST_NON && sp == 0 && ctx[0] == ST_NON &&
                        room == cap_limit() && !err_seen)
                        err_seen = 1'b1;
                    else
                    begin
                        close_more();
                        start_word();
                        again = 1'b1;
                    end
                ACT_DONE, ACT_FINI:
                begin
                    put(1'b0, CHAR_NUL, 1'b1, STAT_EOL);
                    start_word();
                end
                default: ;
            endcase
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t e;
        int      n0;
        if (!rst_n)
        begin
            limit = LIMIT_RESET;
            start_word();
            word_q.delete();
            errors  = 0;
            pending = 0;
        end
        else
        begin
            // Compare the result first; no item can produce one in its own cycle.
            if (words.valid && words.ready)
            begin
                if (word_q.size() == 0)
                begin
                    $error("unexpected result: char_valid=%0d out_char=%0h word_end=%0d",
                           words.char_valid, words.out_char, words.word_end);
                    errors++;
                end
                else
                begin
                    e = word_q.pop_front();
                    if (words.char_valid !== e.char_valid)
                    begin
                        $error("char_valid: expected %0d, actual %0d",
                               e.char_valid, words.char_valid);
                        errors++;
                    end
                    if (words.out_char !== e.out_char)
                    begin
                        $error("out_char: expected %0h, actual %0h", e.out_char, words.out_char);
                        errors++;
                    end
                    if (words.word_end !== e.word_end)
                    begin
                        $error("word_end: expected %0d, actual %0d", e.word_end, words.word_end);
                        errors++;
                    end
                    if (words.status !== e.status)
                    begin
                        $error("status: expected %0d, actual %0d", e.status, words.status);
                        errors++;
                    end
                    if (words.last !== e.last)
                    begin
                        $error("last: expected %0d, actual %0d", e.last, words.last);
                        errors++;
                    end
                end
            end
            if (word_limit_we)
                limit = word_limit_wdata;
            if (chars.valid && chars.ready)
            begin
                n0 = word_q.size();
                case (chars.op)
                    OP_TABLE: act_mem[{chars.table_row, chars.character}] = chars.action_code;
                    OP_EOF:
                    begin
                        put(1'b0, CHAR_NUL, 1'b1, STAT_EOF);
                        start_word();
                    end
                    OP_PARSE: parse_char(chars.character);
                    default: ;
                endcase
                if (word_q.size() > n0)
                    word_q[word_q.size()-1].last = 1'b1;
            end
            pending = word_q.size();
        end
    end

endmodule

### tb/tb_table_driven_pushdown_tokenizer.sv
// ============================================================================
// tb_table_driven_pushdown_tokenizer
// Loads the action table for every character the stimulus uses, with a small
// lexer grammar among random entries, then drives directed sequences (nesting
// past the stack depth, endless continue and back off, escapes, quotes, end
// of input) and short random text under several word limits. A checker module
// predicts and compares every result; this module makes stimulus and gives
// the verdict.
// ============================================================================
module tb_table_driven_pushdown_tokenizer;
    import tdpt_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic               clk;
    logic               rst_n;
    logic               word_limit_we;
    logic [LIMIT_W-1:0] word_limit_wdata;
    int                 errors;
    int                 pending;
    bit                 calm;      // no idling on either side while set
    string              charset;   // characters with loaded table columns

    tdpt_in_if  chars ();
    tdpt_out_if words ();

    table_driven_pushdown_tokenizer uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .word_limit_we    (word_limit_we),
        .word_limit_wdata (word_limit_wdata),
        .chars            (chars.sink),
        .words            (words.source)
    );

    tdpt_checker chk (
        .clk              (clk),
        .rst_n            (rst_n),
        .word_limit_we    (word_limit_we),
        .word_limit_wdata (word_limit_wdata),
        .chars            (chars),
        .words            (words),
        .errors           (errors),
        .pending          (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Result side: stall at random, with a 27 percent chance, unless calm.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            words.ready <= 1'b0;
        else
            words.ready <= calm || ($urandom_range(0, 99) >= 27);
    end

    // Small grammar: letters build words, quotes and escapes nest, comments
    // and parentheses push contexts. Returns 1 when the pair belongs to it.
    function automatic bit grammar(input logic [2:0] row, input logic [7:0] c,
                                   output logic [4:0] act);
        bit letter;
        letter = (c >= "a" && c <= "h");
        act    = ACT_SKIP;
        if (c == "(")
            act = ACT_IGNORE;
        else if (c == ")")
            act = ACT_RESTORE;
        else if (row == ST_NON)
        begin
            if (letter)           act = ACT_APPEND;
            else if (c == " ")    act = ACT_SKIP;
            else if (c == "\n")   act = ACT_DONE;
            else if (c == ";")    act = ACT_FINI;
            else if (c == ",")    act = ACT_APPEND_END;
            else if (c == "\"")   act = ACT_DQUOTE;
            else if (c == "'")    act = ACT_SQUOTE;
            else if (c == "\\")   act = ACT_ESCAPE;
            else if (c == "#")    act = ACT_COMMENT;
            else if (c == "z")    act = ACT_CONT;
            else if (c == "!")    act = ACT_BACKOFF;
            else return 1'b0;
        end
        else if (row == ST_SOM || row == ST_AFT)
        begin
            if (letter)           act = (row == ST_SOM) ? ACT_APPEND : ACT_BACKOFF;
            else if (c == " ")    act = (row == ST_SOM) ? ACT_TRAIL : ACT_SKIP;
            else if (c == "\n" || c == "!" || c == ";")
                                  act = ACT_BACKOFF;
            else if (c == ",")    act = ACT_APPEND_END;
            else if (c == "\"")   act = ACT_DQUOTE;
            else if (c == "'")    act = ACT_SQUOTE;
            else if (c == "\\")   act = ACT_ESCAPE;
            else if (c == "#")    act = ACT_COMMENT;
            else if (c == "z")    act = ACT_CONT;
            else return 1'b0;
        end
        else if (row == ST_SIN)
        begin
            if (c == "'")         act = ACT_UNQUOTE;
            else if (c == "\\")   act = ACT_LQAPP;
            else if (letter || c == " " || c == "," || c == "z")
                                  act = ACT_QAPP;
            else return 1'b0;
        end
        else if (row == ST_DBL)
        begin
            if (c == "\"")        act = ACT_UNQUOTE;
            else if (c == "\\")   act = ACT_ESCAPE;
            else if (letter || c == " " || c == ",")
                                  act = ACT_QAPP;
            else if (c == "z")    act = ACT_CONT;
            else return 1'b0;
        end
        else if (row == ST_ESC)
        begin
            if (letter || c == "\\" || c == "\"" || c == "\n" || c == " ")
                                  act = ACT_ESCAPP;
            else return 1'b0;
        end
        else if (row == ST_COM)
        begin
            if (c == "\n")        act = ACT_CONT;
            else if (letter || c == " " || c == ",") act = ACT_SKIP;
            else return 1'b0;
        end
        else
        begin
            if (letter)           act = ACT_SKIP;
            else if (c == "z")    act = ACT_CONT;
            else return 1'b0;
        end
        return 1'b1;
    endfunction

    // Offer one item; idle first at random, hold until the block takes it.
    task automatic send(input logic [1:0] op, input logic [7:0] c,
                        input logic [2:0] row, input logic [4:0] act);
        if (!calm && $urandom_range(0, 99) < 27)
        begin
            chars.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < 40);
        end
        chars.valid       <= 1'b1;
        chars.op          <= op;
        chars.character   <= c;
        chars.table_row   <= row;
        chars.action_code <= act;
        @(posedge clk);
        while (!chars.ready)
            @(posedge clk);
    endtask

    // Grammar code where the pair belongs to it, a random code elsewhere
    // (including the codes above finish, which act as skip).
    task automatic load_entry(input logic [2:0] r, input logic [7:0] c);
        logic [4:0] g;
        if (grammar(r, c, g))
            send(OP_TABLE, c, r, g);
        else
            send(OP_TABLE, c, r, 5'($urandom));
    endtask

    task automatic feed(input logic [7:0] c);
        send(OP_PARSE, c, 3'($urandom), 5'($urandom));
    endtask

    task automatic feed_text(input string s);
        for (int i = 0; i < s.len(); i++)
            feed(s[i]);
    endtask

    // Drain every expected result, then allow the block to settle.
    task automatic settle();
        chars.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic set_limit(input logic [LIMIT_W-1:0] v);
        settle();
        word_limit_we    <= 1'b1;
        word_limit_wdata <= v;
        @(posedge clk);
        word_limit_we    <= 1'b0;
        @(posedge clk);
    endtask

    // Random text over the loaded characters, some noise, rewrites, end of input and unused operations.
    task automatic random_text(input int count);
        logic [4:0] g;
        logic [7:0] c;
        logic [2:0] r;
        int         p;
        for (int i = 0; i < count; i++)
        begin
            p = $urandom_range(0, 99);
            if (p < 80)
                feed(charset[$urandom_range(0, charset.len() - 1)]);
            else if (p < 90)
                feed(($urandom_range(0, 1) == 0) ? 8'h00 : 8'hFF);
            else if (p < 95)
            begin
                // rewrite only pairs outside the grammar
                c = charset[$urandom_range(0, charset.len() - 1)];
                r = 3'($urandom_range(0, 7));
                if (!grammar(r, c, g))
                    send(OP_TABLE, c, r, 5'($urandom));
            end
            else if (p < 98)
                send(OP_EOF, 8'($urandom), 3'($urandom), 5'($urandom));
            else
                send(OP_UNUSED, 8'($urandom), 3'($urandom), 5'($urandom));
        end
    endtask

    initial
    begin
        logic [LIMIT_W-1:0] limits [6];
        limits  = '{13'd1, 13'd2, 13'd4096, 13'd8191, 13'd3, 13'd4000};
        charset = "abc ,\n\"'\\#();z!";

        calm              = 1'b0;
        rst_n             <= 1'b0;
        word_limit_we     <= 1'b0;
        word_limit_wdata  <= '0;
        chars.valid       <= 1'b0;
        chars.op          <= OP_PARSE;
        chars.character   <= '0;
        chars.table_row   <= '0;
        chars.action_code <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Load every row for each character the stimulus parses.
        for (int r = 0; r < 8; r++)
        begin
            for (int i = 0; i < charset.len(); i++)
                load_entry(3'(r), charset[i]);
            load_entry(3'(r), 8'h00);
            load_entry(3'(r), 8'hFF);
        end

        // Directed: plain words, quotes, escapes, comment, every end kind.
        feed_text("ab c,\n");
        feed_text("'a\\' \"b\\\"c\"");
        feed_text("a#bb\nz!;");
        send(OP_EOF, 8'hFF, 3'd7, 5'd31);
        send(OP_UNUSED, 8'h00, 3'd0, 5'd0);
        feed(8'hFF);
        feed(8'h00);

        // Nest past the stack depth, then close two levels and feed more text; no idling.
        calm = 1'b1;
        for (int i = 0; i < STACK_DEPTH + 4; i++)
            feed("(");
        feed_text("))a\n");
        calm = 1'b0;

        // Tiny limit: buffer full on append and on the terminator.
        set_limit(13'd1);
        feed_text("abc,a!\\ab\n");

        for (int k = 0; k < 6; k++)
        begin
            set_limit(limits[k]);
            random_text(4);
        end

        settle();
        if (errors == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #3_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
